FILE: sv/psa_pkg.sv
// psa_pkg: shared types, codes and constants for the stack-machine integer alu
// no dependencies
package psa_pkg;

  typedef enum logic [4:0] {
    OP_SHL = 5'd0, OP_SHR = 5'd1, OP_ROR = 5'd2, OP_ROL = 5'd3,
    OP_AND = 5'd4, OP_OR = 5'd5, OP_XOR = 5'd6, OP_NOT = 5'd7,
    OP_GT = 5'd8, OP_GE = 5'd9, OP_EQ = 5'd10, OP_LE = 5'd11,
    OP_LT = 5'd12, OP_NE = 5'd13, OP_NEG = 5'd14, OP_ABS = 5'd15,
    OP_ADD = 5'd16, OP_MUL = 5'd17, OP_SUB = 5'd18, OP_DIV = 5'd19,
    OP_MOD = 5'd20
  } op_t;

  typedef enum logic [2:0] {
    TY_BOOL = 3'd0, TY_BYTE = 3'd1, TY_WORD = 3'd2, TY_SINT = 3'd3, TY_INT = 3'd4
  } ty_t;

  localparam logic [1:0] EXC_NONE    = 2'd0;
  localparam logic [1:0] EXC_DIV0    = 2'd1;
  localparam logic [1:0] EXC_ILLEGAL = 2'd2;

  localparam int DataW = 16;
  localparam int DivLat = DataW;

  typedef struct packed {
    logic [4:0]  mode;
    logic [2:0]  type_sel;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic [15:0] result;
    logic [1:0]  exception;
  } out_word_t;

endpackage

FILE: sv/psa_div.sv
// psa_div: pipelined unsigned 16-bit divider, one quotient bit per stage
// depends on psa_pkg
module psa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [15:0] in_a,
  input  logic [15:0] in_b,
  input  logic [15:0] in_tag,
  input  logic        in_want_mod,
  input  logic        in_neg_q,
  input  logic        in_neg_r,
  input  logic [15:0] in_side,
  output logic        out_vld,
  output logic [15:0] out_q,
  output logic [15:0] out_r,
  output logic [15:0] out_tag,
  output logic [15:0] out_side,
  output logic        out_want_mod,
  output logic        out_neg_q,
  output logic        out_neg_r
);

  localparam int N = psa_pkg::DivLat;

  typedef struct packed {
    logic [15:0] quo;
    logic [16:0] rem;
    logic [15:0] dsr;
    logic [15:0] tag;
    logic [15:0] side;
    logic        want_mod;
    logic        neg_q;
    logic        neg_r;
  } dstage_t;

  dstage_t     st_r  [N+1];
  logic [N:0]  vld_r;
  dstage_t     st_nxt [N+1];

  always_comb begin
    st_nxt[0] = '{quo: in_a, rem: '0, dsr: in_b, tag: in_tag, side: in_side,
                  want_mod: in_want_mod, neg_q: in_neg_q, neg_r: in_neg_r};
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [16:0] sh;
    logic [16:0] df;
    always_comb begin
      sh = {st_r[i].rem[15:0], st_r[i].quo[15]};
      df = sh - {1'b0, st_r[i].dsr};
      st_nxt[i+1] = st_r[i];
      if (!df[16]) begin
        st_nxt[i+1].rem = df;
        st_nxt[i+1].quo = {st_r[i].quo[14:0], 1'b1};
      end else begin
        st_nxt[i+1].rem = sh;
        st_nxt[i+1].quo = {st_r[i].quo[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= N; k++) begin
      st_r[k] <= st_nxt[k];
    end
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  assign out_vld      = vld_r[N];
  assign out_q        = st_r[N].quo;
  assign out_r        = st_r[N].rem[15:0];
  assign out_tag      = st_r[N].tag;
  assign out_side     = st_r[N].side;
  assign out_want_mod = st_r[N].want_mod;
  assign out_neg_q    = st_r[N].neg_q;
  assign out_neg_r    = st_r[N].neg_r;

endmodule

FILE: sv/plc_stack_alu_8_16_core.sv
// plc_stack_alu_8_16_core: one operation of a stack-machine integer alu per cycle.
// busy is always low: a new word may be started in every cycle. Every word passes the
// decode register, the divider's input rank, its 16 quotient stages and the output register,
// so its result word is on out_valid after the output register; the receiver cannot stall.
// depends on psa_pkg and psa_div
module plc_stack_alu_8_16_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psa_pkg::in_word_t   in_word,
  output logic                out_valid,
  output psa_pkg::out_word_t  out_word
);

  // stage 1: decode, operand prep
  logic        s1_vld_r;
  logic [4:0]  s1_mode_r;
  logic        s1_wide_r, s1_ill_r, s1_bool_r, s1_arith_r, s1_dz_r;
  logic [15:0] s1_x_r, s1_y_r, s1_b_r, s1_ax_r, s1_ay_r;
  logic        s1_nx_r, s1_ny_r;

  logic        wide, ill, bl, lg, ar;
  logic [15:0] x, y, ax, ay;
  logic        nx, ny, dz;

  always_comb begin
    wide = (in_word.type_sel == psa_pkg::TY_WORD) || (in_word.type_sel == psa_pkg::TY_INT);
    bl = (in_word.type_sel == psa_pkg::TY_BOOL) && (in_word.mode <= psa_pkg::OP_NE);
    lg = ((in_word.type_sel == psa_pkg::TY_BYTE) || (in_word.type_sel == psa_pkg::TY_WORD))
         && (in_word.mode <= psa_pkg::OP_NOT);
    ar = ((in_word.type_sel == psa_pkg::TY_SINT) || (in_word.type_sel == psa_pkg::TY_INT))
         && (in_word.mode >= psa_pkg::OP_NEG) && (in_word.mode <= psa_pkg::OP_MOD);
    ill = !(bl || lg || ar);
    if (wide) begin
      x = in_word.operand_a;
      y = in_word.operand_b;
    end else begin
      x = {{8{in_word.operand_a[7]}}, in_word.operand_a[7:0]};
      y = {{8{in_word.operand_b[7]}}, in_word.operand_b[7:0]};
    end
    nx = x[15];
    ny = y[15];
    ax = nx ? (16'd0 - x) : x;
    ay = ny ? (16'd0 - y) : y;
    dz = (y == 16'd0);
  end

  always_ff @(posedge clk) begin
    s1_mode_r  <= in_word.mode;
    s1_wide_r  <= wide;
    s1_ill_r   <= ill;
    s1_bool_r  <= bl;
    s1_arith_r <= ar;
    s1_dz_r    <= dz;
    s1_x_r     <= x;
    s1_y_r     <= y;
    s1_b_r     <= in_word.operand_b;
    s1_ax_r    <= ax;
    s1_ay_r    <= ay;
    s1_nx_r    <= nx;
    s1_ny_r    <= ny;
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
  end

  // stage 2: compute everything but division
  logic [15:0] r2;
  logic [1:0]  e2;
  logic [15:0] mask2, xm, ym;
  logic [4:0]  wbits;
  logic [15:0] samt;
  logic        sneg;
  logic [15:0] mag;
  logic        left;
  logic [3:0]  rn;
  logic [31:0] rdbl;
  logic [15:0] prod;

  always_comb begin
    mask2 = s1_wide_r ? 16'hFFFF : 16'h00FF;
    wbits = s1_wide_r ? 5'd16 : 5'd8;
    xm = s1_x_r & mask2;
    ym = s1_y_r & mask2;
    samt = s1_b_r;
    sneg = samt[15];
    mag = sneg ? (16'd0 - samt) : samt;
    left = (s1_mode_r == psa_pkg::OP_SHL) ^ sneg;
    rn = s1_wide_r ? s1_b_r[3:0] : {1'b0, s1_b_r[2:0]};
    prod = s1_x_r * s1_y_r;
    rdbl = '0;
    r2 = '0;
    e2 = psa_pkg::EXC_NONE;
    if (s1_ill_r) begin
      e2 = psa_pkg::EXC_ILLEGAL;
    end else if (s1_bool_r) begin
      unique case (s1_mode_r)
        psa_pkg::OP_SHL, psa_pkg::OP_SHR: r2 = {15'd0, (s1_b_r == 16'd0) & s1_x_r[0]};
        psa_pkg::OP_ROR, psa_pkg::OP_ROL: r2 = {15'd0, s1_x_r[0]};
        psa_pkg::OP_AND: r2 = {15'd0, s1_x_r[0] & s1_b_r[0]};
        psa_pkg::OP_OR:  r2 = {15'd0, s1_x_r[0] | s1_b_r[0]};
        psa_pkg::OP_XOR: r2 = {15'd0, s1_x_r[0] ^ s1_b_r[0]};
        psa_pkg::OP_NOT: r2 = {15'd0, ~s1_x_r[0]};
        psa_pkg::OP_GT:  r2 = {15'd0, s1_x_r[0] & ~s1_b_r[0]};
        psa_pkg::OP_GE:  r2 = {15'd0, s1_x_r[0] | ~s1_b_r[0]};
        psa_pkg::OP_EQ:  r2 = {15'd0, ~(s1_x_r[0] ^ s1_b_r[0])};
        psa_pkg::OP_LE:  r2 = {15'd0, ~s1_x_r[0] | s1_b_r[0]};
        psa_pkg::OP_LT:  r2 = {15'd0, ~s1_x_r[0] & s1_b_r[0]};
        default:         r2 = {15'd0, s1_x_r[0] ^ s1_b_r[0]};
      endcase
    end else if (!s1_arith_r) begin
      unique case (s1_mode_r)
        psa_pkg::OP_SHL, psa_pkg::OP_SHR: begin
          if (mag >= {11'd0, wbits}) r2 = '0;
          else if (left) r2 = (xm << mag[3:0]) & mask2;
          else r2 = xm >> mag[3:0];
        end
        psa_pkg::OP_ROR: begin
          rdbl = s1_wide_r ? {xm, xm} : {16'd0, xm[7:0], xm[7:0]};
          r2 = 16'(rdbl >> rn) & mask2;
        end
        psa_pkg::OP_ROL: begin
          rdbl = s1_wide_r ? {xm, xm} : {16'd0, xm[7:0], xm[7:0]};
          r2 = s1_wide_r ? 16'((rdbl << rn) >> 16) : 16'(({16'd0, xm[7:0], xm[7:0]} << rn) >> 8)
               & mask2;
        end
        psa_pkg::OP_AND: r2 = xm & ym;
        psa_pkg::OP_OR:  r2 = xm | ym;
        psa_pkg::OP_XOR: r2 = xm ^ ym;
        default:         r2 = ~xm & mask2;
      endcase
    end else begin
      unique case (s1_mode_r)
        psa_pkg::OP_NEG: r2 = (16'd0 - s1_x_r) & mask2;
        psa_pkg::OP_ABS: r2 = s1_ax_r & mask2;
        psa_pkg::OP_ADD: r2 = (s1_x_r + s1_y_r) & mask2;
        psa_pkg::OP_MUL: r2 = prod & mask2;
        psa_pkg::OP_SUB: r2 = (s1_x_r - s1_y_r) & mask2;
        default: begin
          if (s1_dz_r) e2 = psa_pkg::EXC_DIV0;
        end
      endcase
    end
  end

  logic is_div;
  assign is_div = s1_arith_r && !s1_dz_r &&
                  ((s1_mode_r == psa_pkg::OP_DIV) || (s1_mode_r == psa_pkg::OP_MOD));

  // side word: {12 unused zero bits, div flag, wide, exception}; the non-division result rides in tag
  logic        d_vld, d_wm, d_nq, d_nr;
  logic [15:0] d_q, d_r, d_tag, d_side;

  psa_div u_div (
    .clk(clk), .rst_n(rst_n),
    .in_vld(s1_vld_r),
    .in_a(s1_ax_r), .in_b(s1_ay_r),
    .in_tag(r2),
    .in_want_mod(s1_mode_r == psa_pkg::OP_MOD),
    .in_neg_q(s1_nx_r ^ s1_ny_r),
    .in_neg_r(s1_nx_r),
    .in_side({12'd0, is_div, s1_wide_r, e2}),
    .out_vld(d_vld), .out_q(d_q), .out_r(d_r), .out_tag(d_tag), .out_side(d_side),
    .out_want_mod(d_wm), .out_neg_q(d_nq), .out_neg_r(d_nr)
  );

  // final stage: sign fixup and output register
  logic [15:0] fq, fr, fres, fmask;
  always_comb begin
    fmask = d_side[2] ? 16'hFFFF : 16'h00FF;
    fq = d_nq ? (16'd0 - d_q) : d_q;
    fr = d_nr ? (16'd0 - d_r) : d_r;
    fres = d_side[3] ? ((d_wm ? fr : fq) & fmask) : d_tag;
  end

  logic        ov_r;
  logic [15:0] or_r;
  logic [1:0]  oe_r;
  always_ff @(posedge clk) begin
    or_r <= fres;
    oe_r <= d_side[1:0];
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= d_vld;
  end

  assign busy = 1'b0;
  assign out_valid = ov_r;
  assign out_word.result = or_r;
  assign out_word.exception = oe_r;

endmodule

FILE: verif/plc_stack_alu_8_16_core_tb.sv
// plc_stack_alu_8_16_core_tb: directed table then random words against a local alu predictor
// depends on psa_pkg and plc_stack_alu_8_16_core
module plc_stack_alu_8_16_core_tb;

  localparam int NumRand = 1400;
  localparam int CycleLimit = 200000;
  localparam int Latency = 18;

  typedef struct packed {
    logic [4:0]  mode;
    logic [2:0]  ty;
    logic [15:0] a;
    logic [15:0] b;
    logic        known;
    logic [15:0] res;
    logic [1:0]  exc;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  psa_pkg::in_word_t in_word = '0;
  logic out_valid;
  psa_pkg::out_word_t out_word;

  psa_pkg::out_word_t alu_expected[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 25;
  row_t dir_rows[$];

  plc_stack_alu_8_16_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] shift_bits(logic [15:0] x, logic [15:0] b, int w, bit left);
    int amt;
    amt = $signed(b);
    if (amt >= w || amt <= -w) return '0;
    if (amt < 0) begin
      amt = -amt;
      left = !left;
    end
    if (left) return (w == 8) ? ((x << amt) & 16'h00ff) : (x << amt);
    return x >> amt;
  endfunction

  function automatic logic [15:0] rotate_bits(logic [15:0] x, logic [15:0] b, int w, bit left);
    int n;
    logic [31:0] v;
    n = b & (w - 1);
    if (n == 0) return x;
    v = {16'd0, x};
    if (!left) n = w - n;
    v = (v << n) | (v >> (w - n));
    return (w == 8) ? v[15:0] & 16'h00ff : v[15:0];
  endfunction

  function automatic psa_pkg::out_word_t alu_predict(psa_pkg::in_word_t iw);
    psa_pkg::out_word_t o;
    int w, x, y, r;
    logic [15:0] m, ux, uy;
    o.result = '0;
    o.exception = psa_pkg::EXC_NONE;
    w = (iw.type_sel == psa_pkg::TY_BYTE || iw.type_sel == psa_pkg::TY_SINT) ? 8 : 16;
    m = (w == 8) ? 16'h00ff : 16'hffff;
    ux = iw.operand_a & m;
    uy = iw.operand_b & m;
    x = (w == 8) ? int'($signed(ux[7:0])) : int'($signed(ux));
    y = (w == 8) ? int'($signed(uy[7:0])) : int'($signed(uy));
    if (iw.type_sel == psa_pkg::TY_BOOL && iw.mode <= psa_pkg::OP_NE) begin
      ux = {15'd0, iw.operand_a[0]};
      uy = {15'd0, iw.operand_b[0]};
      case (psa_pkg::op_t'(iw.mode))
        psa_pkg::OP_SHL, psa_pkg::OP_SHR: o.result = (iw.operand_b != 16'd0) ? 16'd0 : ux;
        psa_pkg::OP_ROR, psa_pkg::OP_ROL: o.result = ux;
        psa_pkg::OP_AND: o.result = ux & uy;
        psa_pkg::OP_OR:  o.result = ux | uy;
        psa_pkg::OP_XOR: o.result = ux ^ uy;
        psa_pkg::OP_NOT: o.result = ux ^ 16'd1;
        psa_pkg::OP_GT:  o.result = {15'd0, ux > uy};
        psa_pkg::OP_GE:  o.result = {15'd0, ux >= uy};
        psa_pkg::OP_EQ:  o.result = {15'd0, ux == uy};
        psa_pkg::OP_LE:  o.result = {15'd0, ux <= uy};
        psa_pkg::OP_LT:  o.result = {15'd0, ux < uy};
        default: o.result = {15'd0, ux != uy};
      endcase
    end else if ((iw.type_sel == psa_pkg::TY_BYTE || iw.type_sel == psa_pkg::TY_WORD) &&
                 iw.mode <= psa_pkg::OP_NOT) begin
      case (psa_pkg::op_t'(iw.mode))
        psa_pkg::OP_SHL: o.result = shift_bits(ux, iw.operand_b, w, 1);
        psa_pkg::OP_SHR: o.result = shift_bits(ux, iw.operand_b, w, 0);
        psa_pkg::OP_ROR: o.result = rotate_bits(ux, iw.operand_b, w, 0);
        psa_pkg::OP_ROL: o.result = rotate_bits(ux, iw.operand_b, w, 1);
        psa_pkg::OP_AND: o.result = ux & uy;
        psa_pkg::OP_OR:  o.result = ux | uy;
        psa_pkg::OP_XOR: o.result = ux ^ uy;
        default: o.result = ~ux & m;
      endcase
    end else if ((iw.type_sel == psa_pkg::TY_SINT || iw.type_sel == psa_pkg::TY_INT) &&
                 iw.mode >= psa_pkg::OP_NEG && iw.mode <= psa_pkg::OP_MOD) begin
      r = 0;
      case (psa_pkg::op_t'(iw.mode))
        psa_pkg::OP_NEG: r = -x;
        psa_pkg::OP_ABS: r = (x < 0) ? -x : x;
        psa_pkg::OP_ADD: r = x + y;
        psa_pkg::OP_MUL: r = x * y;
        psa_pkg::OP_SUB: r = x - y;
        psa_pkg::OP_DIV: if (y == 0) o.exception = psa_pkg::EXC_DIV0; else r = x / y;
        default: if (y == 0) o.exception = psa_pkg::EXC_DIV0; else r = x % y;
      endcase
      if (o.exception == psa_pkg::EXC_NONE) o.result = r[15:0] & m;
    end else begin
      o.exception = psa_pkg::EXC_ILLEGAL;
    end
    return o;
  endfunction

  task automatic send_word(psa_pkg::in_word_t iw, bit known, logic [15:0] res,
                           logic [1:0] exc);
    psa_pkg::out_word_t p;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    p = alu_predict(iw);
    if (known && (p.result !== res || p.exception !== exc)) begin
      $display("%0t table row %h: expected %h/%0d predicted %h/%0d", $time, iw, res, exc,
               p.result, p.exception);
      errors++;
    end
    start <= 1'b1;
    in_word <= iw;
    do @(posedge clk); while (busy);
    alu_expected.push_back(p);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h0080;
      4: return 16'($urandom_range(20) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (alu_expected.size() == 0) begin
        $display("%0t unexpected word: actual %h/%0d", $time, out_word.result,
                 out_word.exception);
        errors++;
      end else begin
        if (out_word.result !== alu_expected[0].result ||
            out_word.exception !== alu_expected[0].exception) begin
          $display("%0t mismatch: expected %h/%0d actual %h/%0d", $time,
                   alu_expected[0].result, alu_expected[0].exception,
                   out_word.result, out_word.exception);
          errors++;
        end
        void'(alu_expected.pop_front());
      end
    end
  end

  initial begin
    psa_pkg::in_word_t iw;
    row_t r;
    // directed rows: mode, type, a, b, known, result, exception
    dir_rows = '{
      '{psa_pkg::OP_SHL, psa_pkg::TY_BOOL, 16'h0001, 16'h0000, 1'b1, 16'h0001, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_SHR, psa_pkg::TY_BOOL, 16'h0001, 16'h8000, 1'b1, 16'h0000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_ROL, psa_pkg::TY_BOOL, 16'hffff, 16'h0003, 1'b1, 16'h0001, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_GE,  psa_pkg::TY_BOOL, 16'h0000, 16'h0001, 1'b1, 16'h0000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_NE,  psa_pkg::TY_BOOL, 16'h0001, 16'h0000, 1'b1, 16'h0001, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_SHL, psa_pkg::TY_BYTE, 16'hffff, 16'h0008, 1'b1, 16'h0000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_SHL, psa_pkg::TY_BYTE, 16'h0081, 16'hffff, 1'b1, 16'h0040, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_SHR, psa_pkg::TY_WORD, 16'h8000, 16'h000f, 1'b1, 16'h0001, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_SHR, psa_pkg::TY_WORD, 16'hffff, 16'hfff0, 1'b1, 16'h0000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_ROR, psa_pkg::TY_BYTE, 16'h0001, 16'h0009, 1'b1, 16'h0080, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_ROL, psa_pkg::TY_WORD, 16'h8001, 16'h0001, 1'b1, 16'h0003, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_NOT, psa_pkg::TY_WORD, 16'h0000, 16'h1234, 1'b1, 16'hffff, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_XOR, psa_pkg::TY_BYTE, 16'h12ff, 16'h340f, 1'b0, 16'h0000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_NEG, psa_pkg::TY_SINT, 16'h0080, 16'h0000, 1'b1, 16'h0080, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_ABS, psa_pkg::TY_INT,  16'h8000, 16'h0000, 1'b1, 16'h8000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_ADD, psa_pkg::TY_INT,  16'h7fff, 16'h0001, 1'b1, 16'h8000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_MUL, psa_pkg::TY_SINT, 16'h00ff, 16'h0080, 1'b0, 16'h0000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_SUB, psa_pkg::TY_SINT, 16'h0080, 16'h0001, 1'b1, 16'h007f, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_DIV, psa_pkg::TY_INT,  16'h8000, 16'hffff, 1'b1, 16'h8000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_MOD, psa_pkg::TY_INT,  16'h8000, 16'hffff, 1'b1, 16'h0000, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_DIV, psa_pkg::TY_SINT, 16'h00f9, 16'h0002, 1'b1, 16'h00fd, psa_pkg::EXC_NONE},
      '{psa_pkg::OP_MOD, psa_pkg::TY_SINT, 16'h0005, 16'hff00, 1'b1, 16'h0000, psa_pkg::EXC_DIV0},
      '{psa_pkg::OP_ADD, psa_pkg::TY_WORD, 16'h0001, 16'h0001, 1'b1, 16'h0000,
        psa_pkg::EXC_ILLEGAL},
      '{5'd31, 3'd7, 16'hffff, 16'h0000, 1'b1, 16'h0000, psa_pkg::EXC_ILLEGAL},
      '{psa_pkg::OP_DIV, psa_pkg::TY_BOOL, 16'h0001, 16'h0000, 1'b1, 16'h0000,
        psa_pkg::EXC_ILLEGAL}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      iw = '{r.mode, r.ty, r.a, r.b};
      send_word(iw, r.known, r.res, r.exc);
    end
    for (int n = 0; n < NumRand; n++) begin
      idle_pct = (n >= 500 && n < 800) ? 0 : 25;
      if ($urandom_range(9) == 0) begin
        iw.mode = 5'($urandom);
        iw.type_sel = 3'($urandom);
      end else begin
        iw.type_sel = 3'($urandom_range(psa_pkg::TY_INT));
        case (iw.type_sel)
          psa_pkg::TY_BOOL: iw.mode = 5'($urandom_range(psa_pkg::OP_NE));
          psa_pkg::TY_BYTE, psa_pkg::TY_WORD: iw.mode = 5'($urandom_range(psa_pkg::OP_NOT));
          default: iw.mode = 5'($urandom_range(psa_pkg::OP_MOD, psa_pkg::OP_NEG));
        endcase
      end
      iw.operand_a = pick_operand();
      iw.operand_b = pick_operand();
      send_word(iw, 1'b0, 16'h0000, psa_pkg::EXC_NONE);
    end
    start <= 1'b0;
    while (alu_expected.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/psa_pkg.sv
sv/psa_div.sv
sv/plc_stack_alu_8_16_core.sv
verif/plc_stack_alu_8_16_core_tb.sv
